// ===== src/slxd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_pkg: shared constants and types of the sync/length/XOR deframer.
// Holds the frame layout, the result status codes, the frame outcome codes
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package slxd_pkg;

  // Frame layout: sync, type, four timestamp bytes, length, payload, checksum.
  localparam int POS_TYPE       = 1;
  localparam int POS_TS         = 2;
  localparam int POS_LEN        = 6;
  localparam int HEADER_BYTES   = 7;
  localparam int FRAME_OVERHEAD = 8;

  // Default store depth and register reset value.
  localparam int          DEFAULT_DEPTH = 64;
  localparam logic [7:0]  SYNC_RESET    = 8'hAA;

  // Width used for length and fill comparisons (covers 8 + 255).
  localparam int CMP_W  = 10;
  // Width of the reported length and payload index fields.
  localparam int LEN_W  = 6;
  localparam int PIDX_W = 6;

  // Result status codes.
  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Outcome of one received byte.
  localparam logic [2:0] OC_NONE  = 3'd0;
  localparam logic [2:0] OC_OVF   = 3'd1;
  localparam logic [2:0] OC_BAD   = 3'd2;
  localparam logic [2:0] OC_EMPTY = 3'd3;
  localparam logic [2:0] OC_GOOD  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // a byte is taken this cycle
    logic rd_en;     // read the next payload byte from the store
    logic load_one;  // load the single result of the finished frame
    logic load_pay;  // load one payload result
  } slxd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] outcome;   // what the byte on the input would cause
    logic       out_free;  // the output register can take a result
    logic       idx_last;  // the current payload index is the final one
  } slxd_sts_t;

endpackage : slxd_pkg
`default_nettype wire

// ===== src/slxd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_ctrl: deframer controller.
// Takes bytes while idle, then sequences either one summary result or the
// read-and-load steps of the payload run of a good frame.
// ----------------------------------------------------------------------------
module slxd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  slxd_pkg::slxd_sts_t  sts,
  output slxd_pkg::slxd_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ONE  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_LD   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.load_one = 1'b0;
    cmd.load_pay = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (sts.outcome == slxd_pkg::OC_GOOD) begin
            state_nxt = S_RD;
          end else if (sts.outcome != slxd_pkg::OC_NONE) begin
            state_nxt = S_ONE;
          end
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          cmd.load_one = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.load_pay = 1'b1;
          state_nxt    = sts.idx_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : slxd_ctrl
`default_nettype wire

// ===== src/slxd_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_dpath: deframer datapath.
// Frame store memory, fill counter, running XOR, captured header fields,
// payload index counter and the output result register.
// ----------------------------------------------------------------------------
module slxd_dpath #(
  parameter int BUFFER_DEPTH = slxd_pkg::DEFAULT_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  [7:0]           sync_byte,
  input  wire  [7:0]           rx_byte,
  input  slxd_pkg::slxd_cmd_t  cmd,
  output slxd_pkg::slxd_sts_t  sts,
  input  wire                  out_tready,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [7:0]           out_type,
  output logic [31:0]          out_ts,
  output logic [slxd_pkg::LEN_W-1:0]  out_len,
  output logic                 out_pvalid,
  output logic [7:0]           out_pbyte,
  output logic [slxd_pkg::PIDX_W-1:0] out_pidx,
  output logic                 out_last
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CmpW   = slxd_pkg::CMP_W;
  localparam int LenW   = slxd_pkg::LEN_W;
  localparam int PidxW  = slxd_pkg::PIDX_W;

  logic [7:0]        mem_r [BUFFER_DEPTH];
  logic [7:0]        rd_data_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_inc;
  logic [7:0]        xor_r;
  logic [7:0]        xor_nxt;
  logic [7:0]        type_r;
  logic [31:0]       ts_r;
  logic [7:0]        len_r;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [2:0]        kind_r;
  logic [2:0]        outcome;
  logic              out_free;
  logic              idx_last;
  logic              take;
  logic              ovf;
  logic              done;
  logic              hdr;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [7:0]        out_type_r;
  logic [31:0]       out_ts_r;
  logic [LenW-1:0]   out_len_r;
  logic              out_pvalid_r;
  logic [7:0]        out_pbyte_r;
  logic [PidxW-1:0]  out_pidx_r;
  logic              out_last_r;

  // Outcome of the byte on the input, given the current fill and XOR.
  // A frame can only complete once its length byte is held.
  always_comb begin
    take     = (fill_r != '0) || (rx_byte == sync_byte);
    fill_inc = fill_r + FILL_W'(1);
    xor_nxt  = xor_r ^ rx_byte;
    ovf      = (fill_inc == FILL_W'(BUFFER_DEPTH));
    done     = (fill_r >= FILL_W'(slxd_pkg::HEADER_BYTES)) &&
               (CmpW'(fill_inc) == CmpW'(len_r) + CmpW'(slxd_pkg::FRAME_OVERHEAD));
    priority if (!take) begin
      outcome = slxd_pkg::OC_NONE;
    end else if (ovf) begin
      outcome = slxd_pkg::OC_OVF;
    end else if (!done) begin
      outcome = slxd_pkg::OC_NONE;
    end else if (xor_nxt != 8'd0) begin
      outcome = slxd_pkg::OC_BAD;
    end else if (len_r == 8'd0) begin
      outcome = slxd_pkg::OC_EMPTY;
    end else begin
      outcome = slxd_pkg::OC_GOOD;
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign idx_last = (CmpW'(idx_r) + CmpW'(1) == CmpW'(len_r));
  assign sts      = '{outcome: outcome, out_free: out_free, idx_last: idx_last};

  // Fill counter and running XOR; both clear when a frame ends.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      xor_r  <= 8'd0;
    end else if (cmd.accept && take) begin
      if (ovf || done) begin
        fill_r <= '0;
        xor_r  <= 8'd0;
      end else begin
        fill_r <= fill_inc;
        xor_r  <= xor_nxt;
      end
    end
  end

  // Header capture, outcome latch and payload index.
  always_ff @(posedge clk) begin
    if (cmd.accept && take) begin
      if (fill_r == FILL_W'(slxd_pkg::POS_TYPE)) begin
        type_r <= rx_byte;
      end
      if (fill_r >= FILL_W'(slxd_pkg::POS_TS) && fill_r < FILL_W'(slxd_pkg::POS_LEN)) begin
        ts_r <= {ts_r[23:0], rx_byte};
      end
      if (fill_r == FILL_W'(slxd_pkg::POS_LEN)) begin
        len_r <= rx_byte;
      end
    end
    if (cmd.accept) begin
      kind_r <= outcome;
      idx_r  <= '0;
    end else if (cmd.load_pay) begin
      idx_r <= idx_r + ADDR_W'(1);
    end
  end

  // Frame store: one write port at the fill position, one registered read.
  assign rd_addr = idx_r + ADDR_W'(slxd_pkg::HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (cmd.accept && take) begin
      mem_r[fill_r[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Output result register.
  assign hdr = (kind_r != slxd_pkg::OC_OVF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_one || cmd.load_pay) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_one) begin
      priority if (kind_r == slxd_pkg::OC_OVF) begin
        out_status_r <= slxd_pkg::ST_OVF;
      end else if (kind_r == slxd_pkg::OC_BAD) begin
        out_status_r <= slxd_pkg::ST_BAD;
      end else begin
        out_status_r <= slxd_pkg::ST_GOOD;
      end
      out_type_r   <= hdr ? type_r : 8'd0;
      out_ts_r     <= hdr ? ts_r : 32'd0;
      out_len_r    <= hdr ? len_r[LenW-1:0] : '0;
      out_pvalid_r <= 1'b0;
      out_pbyte_r  <= 8'd0;
      out_pidx_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_pay) begin
      out_status_r <= slxd_pkg::ST_GOOD;
      out_type_r   <= type_r;
      out_ts_r     <= ts_r;
      out_len_r    <= len_r[LenW-1:0];
      out_pvalid_r <= 1'b1;
      out_pbyte_r  <= rd_data_r;
      out_pidx_r   <= PidxW'(idx_r);
      out_last_r   <= idx_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_type   = out_type_r;
  assign out_ts     = out_ts_r;
  assign out_len    = out_len_r;
  assign out_pvalid = out_pvalid_r;
  assign out_pbyte  = out_pbyte_r;
  assign out_pidx   = out_pidx_r;
  assign out_last   = out_last_r;

endmodule : slxd_dpath
`default_nettype wire

// ===== src/sync_length_xor_packet_deframer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_xor_packet_deframer_top: sync/length/XOR frame deframer.
//
// Input stream: one received serial byte per request. While no frame is
// open, bytes other than the sync byte are dropped. A frame is sync, type,
// four timestamp bytes (big-endian), length L, L payload bytes and an XOR
// checksum over all earlier frame bytes.
// Output stream: a good frame gives one result per payload byte (tlast on
// the final one), or one result if L is zero; a bad checksum gives one
// error result and a full store gives one overflow result.
// Throughput: a byte is taken every cycle while a frame is collected.
// After the final byte, the controller moves to S_ONE and loads a single
// result once the output register is free; a payload run handles each byte
// as a store read, then an output load, bounded by the single read port of
// the frame store. No byte is taken during a run.
// Reset: store empty, sync byte 0xAA, output empty.
// A stalled receiver holds the output register; bytes are still taken
// until the next result must be loaded, then the controller waits.
// Configuration: APB register 0 (byte address 0) holds the sync byte.
// ----------------------------------------------------------------------------
module sync_length_xor_packet_deframer_top #(
  parameter int BUFFER_DEPTH = slxd_pkg::DEFAULT_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input stream.
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,     // [7:0] rx_byte
  // Output stream.
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,    // [7:0] packet_type, [39:8] timestamp,
                                    // [45:40] data_length, [53:46] payload_byte,
                                    // [59:54] payload_index, [63:60] zero
  output logic [2:0]  out_tuser,    // [1:0] status, [2] payload_valid
  output logic        out_tlast,
  // Configuration port.
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  slxd_pkg::slxd_cmd_t cmd;
  slxd_pkg::slxd_sts_t sts;

  logic [7:0]  sync_r;
  logic [1:0]  res_status;
  logic [7:0]  res_type;
  logic [31:0] res_ts;
  logic [slxd_pkg::LEN_W-1:0]  res_len;
  logic        res_pvalid;
  logic [7:0]  res_pbyte;
  logic [slxd_pkg::PIDX_W-1:0] res_pidx;

  // Configuration register: sync byte at register 0.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= slxd_pkg::SYNC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      sync_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {24'd0, sync_r};

  slxd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slxd_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .sync_byte  (sync_r),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_type   (res_type),
    .out_ts     (res_ts),
    .out_len    (res_len),
    .out_pvalid (res_pvalid),
    .out_pbyte  (res_pbyte),
    .out_pidx   (res_pidx),
    .out_last   (out_tlast)
  );

  // Result packing.
  assign out_tdata = {4'd0, res_pidx, res_pbyte, res_len, res_ts, res_type};
  assign out_tuser = {res_pvalid, res_status};

  // A result is loaded only when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_one || cmd.load_pay) |-> sts.out_free)
    else $error("result loaded into a full output register");

  // A completed good frame starts its payload run with a store read.
  a_good_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.outcome == slxd_pkg::OC_GOOD) |=> cmd.rd_en)
    else $error("good frame did not start a payload read");

  // No byte is taken while a payload read is in flight.
  a_no_take_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> !in_tready)
    else $error("input taken during a payload run");

  // Error and overflow results are always the single, final result.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != slxd_pkg::ST_GOOD) |-> (out_tlast && !out_tuser[2]))
    else $error("error result not marked last or carries payload");

endmodule : sync_length_xor_packet_deframer_top
`default_nettype wire

// ===== verif/deframe_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_scoreboard_pkg: expected-result tracking for the deframer bench.
// The scoreboard follows the frame store, fill level and running XOR of the
// block, turns every accepted byte into the results it should produce, and
// compares the results leaving the block against them in order.
// ----------------------------------------------------------------------------
package deframe_scoreboard_pkg;
  import slxd_pkg::*;

  // One result of the deframer, split into its fields.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  ptype;
    logic [31:0] tstamp;
    logic [5:0]  dlen;
    logic        pvalid;
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic        is_last;
  } deframe_result_t;

  class deframe_scoreboard;
    int unsigned depth;
    logic [7:0]  frame_bytes [];
    int unsigned fill;
    logic [7:0]  xsum;
    logic [7:0]  sync_value;
    deframe_result_t pending_results [$];
    int unsigned errors;

    function new(int unsigned store_depth);
      depth = store_depth;
      frame_bytes = new[store_depth];
      fill = 0;
      xsum = 8'h00;
      sync_value = SYNC_RESET;
      errors = 0;
    endfunction

    function void set_sync(logic [7:0] value);
      sync_value = value;
    endfunction

    function int unsigned fill_level();
      return fill;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Result carrying the header fields of the frame now in the store.
    function deframe_result_t header_result(logic [1:0] status);
      deframe_result_t r;
      r = '0;
      r.status  = status;
      r.ptype   = frame_bytes[POS_TYPE];
      r.tstamp  = {frame_bytes[POS_TS], frame_bytes[POS_TS + 1],
                   frame_bytes[POS_TS + 2], frame_bytes[POS_TS + 3]};
      r.dlen    = frame_bytes[POS_LEN][5:0];
      r.is_last = 1'b1;
      return r;
    endfunction

    // Advance the frame state by one accepted byte and queue its results.
    function void note_byte(logic [7:0] b);
      deframe_result_t r;
      int unsigned len;
      if (fill == 0 && b != sync_value) return;
      if (fill < depth) frame_bytes[fill] = b;
      fill++;
      xsum ^= b;
      // A full store wins over completion.
      if (fill >= depth) begin
        fill = 0;
        xsum = 8'h00;
        r = '0;
        r.status  = ST_OVF;
        r.is_last = 1'b1;
        pending_results.push_back(r);
        return;
      end
      if (fill < FRAME_OVERHEAD) return;
      len = frame_bytes[POS_LEN];
      if (fill < FRAME_OVERHEAD + len) return;
      fill = 0;
      if (xsum != 8'h00) begin
        xsum = 8'h00;
        pending_results.push_back(header_result(ST_BAD));
        return;
      end
      if (len == 0) begin
        pending_results.push_back(header_result(ST_GOOD));
        return;
      end
      // One result per payload byte, the final one marked.
      for (int unsigned i = 0; i < len; i++) begin
        r = header_result(ST_GOOD);
        r.pvalid  = 1'b1;
        r.pbyte   = frame_bytes[HEADER_BYTES + i];
        r.pidx    = i[5:0];
        r.is_last = (i + 1 == len);
        pending_results.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one result from the block with the oldest expected one.
    function void check_result(deframe_result_t got);
      deframe_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0h type %0h", got.status, got.ptype);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("packet_type", want.ptype, got.ptype);
      compare_field("timestamp", want.tstamp, got.tstamp);
      compare_field("data_length", want.dlen, got.dlen);
      compare_field("payload_valid", want.pvalid, got.pvalid);
      compare_field("payload_byte", want.pbyte, got.pbyte);
      compare_field("payload_index", want.pidx, got.pidx);
      compare_field("last", want.is_last, got.is_last);
    endfunction
  endclass

endpackage : deframe_scoreboard_pkg

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level bench of the sync/length/XOR packet deframer.
// Feeds noise, good, empty, corrupted, truncated and oversized frames under
// several sync byte settings, with random gaps on both streams, and checks
// every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import slxd_pkg::*;
  import deframe_scoreboard_pkg::*;

  localparam int          DEPTH         = DEFAULT_DEPTH;
  localparam logic [2:0]  REG_SYNC_ADDR = 3'd0;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          PHASE_BYTES   = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata = 8'h00;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [63:0] out_tdata;
  wire  [2:0]  out_tuser;
  wire         out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  bit          idle_on = 1'b1;
  int unsigned cfg_errors = 0;
  int unsigned frame_byte_count;
  logic [7:0]  byte_q [$];
  logic [7:0]  cur_sync = SYNC_RESET;
  deframe_result_t seen;
  deframe_scoreboard sb = new(DEPTH);

  sync_length_xor_packet_deframer_top #(.BUFFER_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver readiness with random stalls.
  always @(posedge clk) begin
    out_tready <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
  end

  // Every accepted byte request advances the prediction.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata);
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.status  = out_tuser[1:0];
      seen.pvalid  = out_tuser[2];
      seen.ptype   = out_tdata[7:0];
      seen.tstamp  = out_tdata[39:8];
      seen.dlen    = out_tdata[45:40];
      seen.pbyte   = out_tdata[53:46];
      seen.pidx    = out_tdata[59:54];
      seen.is_last = out_tlast;
      sb.check_result(seen);
    end
  end

  // Send one byte; tvalid stays high on return unless a gap follows.
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send and clear the bytes built up in byte_q.
  task automatic send_queued();
    frame_byte_count += byte_q.size();
    foreach (byte_q[i]) send_byte(byte_q[i]);
    byte_q.delete();
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == cur_sync) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic void push_header(logic [7:0] ptype, logic [31:0] ts, logic [7:0] len);
    byte_q.push_back(cur_sync);
    byte_q.push_back(ptype);
    byte_q.push_back(ts[31:24]);
    byte_q.push_back(ts[23:16]);
    byte_q.push_back(ts[15:8]);
    byte_q.push_back(ts[7:0]);
    byte_q.push_back(len);
  endfunction

  // Random payload, with the sync byte now and then.
  function automatic void push_payload(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      byte_q.push_back(($urandom_range(9) == 0) ? cur_sync : 8'($urandom_range(255)));
  endfunction

  // Append the XOR checksum, spoiled on request.
  function automatic void push_checksum(bit corrupt);
    logic [7:0] x;
    x = 8'h00;
    foreach (byte_q[i]) x ^= byte_q[i];
    if (corrupt) x ^= 8'($urandom_range(1, 255));
    byte_q.push_back(x);
  endfunction

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_check_sync(input logic [7:0] exp_v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= REG_SYNC_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[7:0] !== exp_v) begin
      $error("sync_byte: expected %0h, actual %0h", exp_v, cfg_prdata[7:0]);
      cfg_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Close any open frame, then wait until every expected result is out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.fill_level() != 0) begin
      send_byte(8'($urandom_range(255)));
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Short directed pass over the corner cases.
  task automatic run_directed();
    // Idle bytes other than the sync byte are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    // Empty good frames with all-zero and all-one headers.
    push_header(8'h00, 32'h0000_0000, 8'd0); push_checksum(1'b0); send_queued();
    push_header(8'hFF, 32'hFFFF_FFFF, 8'd0); push_checksum(1'b0); send_queued();
    // One payload byte, then sync bytes inside the frame.
    push_header(8'h12, 32'h0102_0304, 8'd1);
    byte_q.push_back(8'hFF);
    push_checksum(1'b0); send_queued();
    push_header(cur_sync, {4{cur_sync}}, 8'd3);
    byte_q.push_back(cur_sync); byte_q.push_back(8'h00); byte_q.push_back(cur_sync);
    push_checksum(1'b0); send_queued();
    // Longest payload that fits.
    push_header(8'h5A, 32'h8000_0001, 8'd55); push_payload(55);
    push_checksum(1'b0); send_queued();
    // Checksum mismatches, with and without payload.
    push_header(8'h33, 32'hDEAD_BEEF, 8'd2); push_payload(2);
    push_checksum(1'b1); send_queued();
    push_header(8'h44, 32'h7FFF_FFFF, 8'd0); push_checksum(1'b1); send_queued();
    // Lengths that can only fill the store.
    push_header(8'h66, 32'h1234_5678, 8'd56); push_payload(DEPTH - HEADER_BYTES);
    send_queued();
    push_header(8'h77, 32'h0BAD_F00D, 8'd255); push_payload(DEPTH - HEADER_BYTES);
    send_queued();
  endtask

  // Mostly well-formed frames with random content, plus noise and broken ones.
  task automatic run_random();
    int unsigned pick;
    int unsigned len;
    frame_byte_count = 0;
    while (frame_byte_count < PHASE_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(noise_byte());
      end else if (pick < 13) begin
        len = $urandom_range(56, 255);
        push_header(8'($urandom), 32'($urandom), 8'(len));
        push_payload(DEPTH - HEADER_BYTES);
        send_queued();
      end else if (pick < 22) begin
        len = $urandom_range(0, 8);
        push_header(8'($urandom), 32'($urandom), 8'(len));
        push_payload(len);
        push_checksum(1'b1);
        send_queued();
      end else if (pick < 27) begin
        // Truncated frame: the next bytes run on inside it.
        len = $urandom_range(0, 6);
        push_header(8'($urandom), 32'($urandom), 8'(len));
        push_payload($urandom_range(0, len));
        send_queued();
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 55) : $urandom_range(0, 8);
        push_header(8'($urandom), 32'($urandom), 8'(len));
        push_payload(len);
        push_checksum(1'b0);
        send_queued();
      end
    end
  endtask

  // Main sequence: reset, then one phase per sync byte setting.
  initial begin
    logic [7:0] sync_list [5];
    sync_list = '{SYNC_RESET, 8'h00, 8'hFF, 8'($urandom), SYNC_RESET};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check_sync(SYNC_RESET);
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        cfg_write(REG_SYNC_ADDR, {24'd0, sync_list[p]});
        cur_sync = sync_list[p];
        sb.set_sync(sync_list[p]);
        cfg_check_sync(sync_list[p]);
      end
      idle_on = (p != 2);
      if (p == 0) run_directed();
      run_random();
      drain();
    end
    if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0) begin
      $display("[sync_length_xor_packet_deframer_top] OK");
    end else begin
      $display("[sync_length_xor_packet_deframer_top] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("[sync_length_xor_packet_deframer_top] ERROR");
    $finish;
  end

endmodule : tb_top
